// ===== rtl/qdec_pkg.sv =====
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared constants and controller/datapath command types for the quadrature
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qdec_pkg;

  // Field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PPR_W      = 16;
  localparam int unsigned APB_ADDR_W = 3;

  // Default number of edge events between period latches
  localparam int unsigned EVENTS_PER_PERIOD_DEF = 5;

  // Serial divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Reset values
  localparam logic [DATA_W-1:0] PERIOD_RESET  = 32'h7FFF_FFFF;
  localparam logic              X4_RESET      = 1'b1;
  localparam logic [PPR_W-1:0]  PPR_RESET     = 16'd1;

  // Channel level pairs {A,B}
  localparam logic [1:0] AB_BOTH_HIGH = 2'b11;
  localparam logic [1:0] AB_BOTH_LOW  = 2'b00;

  // Request codes
  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_X4_MODE = 1'b0;
  localparam logic REG_PPR     = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // input transfer: update decoder state
    logic load;     // load divider with current count
    logic step;     // one divider iteration
    logic publish;  // capture result into output register
  } qdec_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last; // current iteration is the final one
  } qdec_status_t;

endpackage

`default_nettype wire

// ===== rtl/qdec_if.sv =====
// ----------------------------------------------------------------------------
// qdec_in_if / qdec_out_if
// Valid/ready channels carrying decoder requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qdec_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic                           chan_a;
  logic                           chan_b;
  logic [qdec_pkg::DATA_W-1:0]    time_us;

  modport source (output valid, output req_type, output chan_a, output chan_b,
                  output time_us, input ready);
  modport sink   (input valid, input req_type, input chan_a, input chan_b,
                  input time_us, output ready);
endinterface

interface qdec_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qdec_pkg::DATA_W-1:0] pulse_count;
  logic signed [qdec_pkg::DATA_W-1:0] revolutions;
  logic signed [qdec_pkg::DATA_W-1:0] period_us;

  modport source (output valid, output pulse_count, output revolutions,
                  output period_us, input ready);
  modport sink   (input valid, input pulse_count, input revolutions,
                  input period_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/qdec_cfg.sv =====
// ----------------------------------------------------------------------------
// qdec_cfg
// APB-style register file: decode mode and pulses per revolution.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [qdec_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [qdec_pkg::DATA_W-1:0]       pwdata,
  output logic      [qdec_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready,
  output logic                                   x4_mode,
  output logic      [qdec_pkg::PPR_W-1:0]        pulses_per_rev
);

  logic                          x4_mode_r;
  logic [qdec_pkg::PPR_W-1:0]    ppr_r;
  logic                          wr_en;
  logic                          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x4_mode_r <= qdec_pkg::X4_RESET;
      ppr_r     <= qdec_pkg::PPR_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        qdec_pkg::REG_X4_MODE: x4_mode_r <= pwdata[0];
        qdec_pkg::REG_PPR:     ppr_r     <= pwdata[qdec_pkg::PPR_W-1:0];
        default:               ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      qdec_pkg::REG_X4_MODE: prdata = {{(qdec_pkg::DATA_W-1){1'b0}}, x4_mode_r};
      qdec_pkg::REG_PPR:
        prdata = {{(qdec_pkg::DATA_W-qdec_pkg::PPR_W){1'b0}}, ppr_r};
      default:               prdata = '0;
    endcase
  end

  assign x4_mode        = x4_mode_r;
  assign pulses_per_rev = ppr_r;

endmodule

`default_nettype wire

// ===== rtl/qdec_dp.sv =====
// ----------------------------------------------------------------------------
// qdec_dp
// Datapath: quadrature state decode, period latch, serial restoring divider
// for revolutions, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_dp #(
  parameter int unsigned EVENTS_PER_PERIOD = qdec_pkg::EVENTS_PER_PERIOD_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire qdec_pkg::qdec_cmd_t                 cmd,
  output qdec_pkg::qdec_status_t                   status,
  input  wire logic                                x4_mode,
  input  wire logic        [qdec_pkg::PPR_W-1:0]   pulses_per_rev,
  input  wire logic                                req_type,
  input  wire logic                                chan_a,
  input  wire logic                                chan_b,
  input  wire logic        [qdec_pkg::DATA_W-1:0]  time_us,
  output logic signed      [qdec_pkg::DATA_W-1:0]  pulse_count,
  output logic signed      [qdec_pkg::DATA_W-1:0]  revolutions,
  output logic signed      [qdec_pkg::DATA_W-1:0]  period_us
);

  localparam int unsigned DW      = qdec_pkg::DATA_W;
  localparam int unsigned PW      = qdec_pkg::PPR_W;
  localparam int unsigned TALLY_W = $clog2(EVENTS_PER_PERIOD + 1);

  // Decoder state
  logic [1:0]          prev_ab_r, prev_ab_nxt;
  logic [DW-1:0]       total_r, total_nxt;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;
  logic [DW-1:0]       stamp_r, stamp_nxt;
  logic [DW-1:0]       period_r, period_nxt;

  // Divider state
  logic [DW-1:0]       quo_r, quo_nxt;
  logic [PW-1:0]       rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  logic [qdec_pkg::STEP_W-1:0] step_r, step_nxt;

  // Result register
  logic [DW-1:0]       res_count_r, res_revs_r, res_period_r;

  logic [1:0]          cur_ab;
  logic [1:0]          diff_ab;
  logic [DW-1:0]       edge_total;
  logic [TALLY_W-1:0]  tally_inc;
  logic [DW-1:0]       elapsed;
  logic [PW-1:0]       divisor;
  logic [PW:0]         shifted;
  logic [PW:0]         trial;

  assign cur_ab  = {chan_a, chan_b};
  assign diff_ab = cur_ab ^ prev_ab_r;

  // Decode one edge event into the new count
  always_comb begin
    edge_total = total_r;
    if (!x4_mode) begin
      if ((prev_ab_r == qdec_pkg::AB_BOTH_HIGH && cur_ab == qdec_pkg::AB_BOTH_LOW) ||
          (prev_ab_r == qdec_pkg::AB_BOTH_LOW && cur_ab == qdec_pkg::AB_BOTH_HIGH)) begin
        edge_total = total_r + DW'(1);
      end else begin
        edge_total = total_r - DW'(1);
      end
    end else if (diff_ab != qdec_pkg::AB_BOTH_HIGH && diff_ab != qdec_pkg::AB_BOTH_LOW) begin
      if (prev_ab_r[0] ^ cur_ab[1]) begin
        edge_total = total_r - DW'(1);
      end else begin
        edge_total = total_r + DW'(1);
      end
    end
  end

  // Next decoder state on an input transfer
  always_comb begin
    prev_ab_nxt = prev_ab_r;
    total_nxt   = total_r;
    tally_nxt   = tally_r;
    stamp_nxt   = stamp_r;
    period_nxt  = period_r;
    tally_inc   = tally_r + TALLY_W'(1);
    elapsed     = time_us - stamp_r;
    if (cmd.accept) begin
      if (req_type == qdec_pkg::REQ_CLEAR) begin
        total_nxt = '0;
      end else begin
        prev_ab_nxt = cur_ab;
        total_nxt   = edge_total;
        tally_nxt   = tally_inc;
        if (tally_inc >= TALLY_W'(EVENTS_PER_PERIOD)) begin
          tally_nxt  = '0;
          stamp_nxt  = time_us;
          period_nxt = edge_total[DW-1] ? (DW'(0) - elapsed) : elapsed;
        end
      end
    end
  end

  // Divider: one restoring step per cycle on the count magnitude
  assign divisor = (pulses_per_rev == '0) ? PW'(1) : pulses_per_rev;
  assign shifted = {rem_r, quo_r[DW-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    if (cmd.load) begin
      neg_nxt  = total_r[DW-1];
      quo_nxt  = total_r[DW-1] ? (DW'(0) - total_r) : total_r;
      rem_nxt  = '0;
      step_nxt = qdec_pkg::STEP_W'(qdec_pkg::DIV_STEPS - 1);
    end else if (cmd.step) begin
      if (trial[PW]) begin
        rem_nxt = shifted[PW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[PW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end
      step_nxt = step_r - qdec_pkg::STEP_W'(1);
    end
  end

  assign status.div_last = (step_r == '0);

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= '0;
      total_r   <= '0;
      tally_r   <= '0;
      stamp_r   <= '0;
      period_r  <= qdec_pkg::PERIOD_RESET;
    end else begin
      prev_ab_r <= prev_ab_nxt;
      total_r   <= total_nxt;
      tally_r   <= tally_nxt;
      stamp_r   <= stamp_nxt;
      period_r  <= period_nxt;
    end
  end

  // Divider registers and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_count_r  <= total_r;
      res_revs_r   <= neg_r ? (DW'(0) - quo_r) : quo_r;
      res_period_r <= period_r;
    end
  end

  assign pulse_count = res_count_r;
  assign revolutions = res_revs_r;
  assign period_us   = res_period_r;

endmodule

`default_nettype wire

// ===== rtl/qdec_ctrl.sv =====
// ----------------------------------------------------------------------------
// qdec_ctrl
// Sequencer: takes one request, runs the divider, then hands the result to
// the output register while tracking its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  input  wire qdec_pkg::qdec_status_t   status,
  output qdec_pkg::qdec_cmd_t           cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;
  logic   in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // Commands for the datapath
  always_comb begin
    cmd.accept  = in_xfer;
    cmd.load    = (state_r == ST_LOAD);
    cmd.step    = (state_r == ST_DIV);
    cmd.publish = (state_r == ST_HOLD) & out_free;
  end

  // Advance state and track the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_xfer) state_r <= ST_LOAD;
        ST_LOAD: state_r <= ST_DIV;
        ST_DIV:  if (status.div_last) state_r <= ST_HOLD;
        ST_HOLD: if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/quadrature_decoder_x2_x4.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_x2_x4
// Sequence: after the input transfer, a load state, then the bit-serial divider
// (one quotient bit per cycle), then the result moves into the output register.
// A new request is taken only after the previous result has entered that register.
// The output register lets a new request enter while a result waits.
// Reset (synchronous, rst_n low): count, tally, stamps cleared, period 7FFFFFFF.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_x2_x4 #(
  parameter int unsigned EVENTS_PER_PERIOD = qdec_pkg::EVENTS_PER_PERIOD_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  qdec_in_if.sink                                in_ch,
  qdec_out_if.source                             out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [qdec_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [qdec_pkg::DATA_W-1:0]       pwdata,
  output logic      [qdec_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready
);

  qdec_pkg::qdec_cmd_t           cmd;
  qdec_pkg::qdec_status_t        status;
  logic                          x4_mode;
  logic [qdec_pkg::PPR_W-1:0]    pulses_per_rev;
  logic                          in_ready;
  logic                          out_valid;

  // Configuration registers
  qdec_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .x4_mode        (x4_mode),
    .pulses_per_rev (pulses_per_rev)
  );

  // Sequencer
  qdec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Decode, period and divide
  qdec_dp #(
    .EVENTS_PER_PERIOD (EVENTS_PER_PERIOD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .x4_mode        (x4_mode),
    .pulses_per_rev (pulses_per_rev),
    .req_type       (in_ch.req_type),
    .chan_a         (in_ch.chan_a),
    .chan_b         (in_ch.chan_b),
    .time_us        (in_ch.time_us),
    .pulse_count    (out_ch.pulse_count),
    .revolutions    (out_ch.revolutions),
    .period_us      (out_ch.period_us)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
